// ===== src/dfs_edge_classifier_unit_assert.svh =====
// Assertion macros shared by the checker.
`ifndef DFS_EDGE_CLASSIFIER_UNIT_ASSERT_SVH
`define DFS_EDGE_CLASSIFIER_UNIT_ASSERT_SVH

// Property checked outside of reset.
`define DFSEC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define DFSEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dfsec_pkg.sv =====
`timescale 1ns / 1ps

package dfsec_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int VTX_W            = 5;
    localparam int CNT_W            = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_NEXT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_TREE     = 2'd0,
        EV_VISITED  = 2'd1,
        EV_COMP_END = 2'd2,
        EV_DONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WALK = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_STEP,
        ST_ROW_WAIT,
        ST_SCAN,
        ST_POP_WAIT,
        ST_RESTART,
        ST_EMIT
    } eng_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [VTX_W-1:0]   from_v;
        logic [VTX_W-1:0]   to_v;
        logic [VTX_W-1:0]   depth;
    } evt_t;

endpackage

// ===== src/dfsec_ram.sv =====
`timescale 1ns / 1ps

module dfsec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dfsec_out_reg.sv =====
`timescale 1ns / 1ps

module dfsec_out_reg
    import dfsec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  evt_t in_evt,
    output logic out_valid,
    input  logic out_ready,
    output evt_t out_evt
);

    logic valid_reg;
    logic valid_next;
    evt_t evt_reg;
    evt_t evt_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        evt_next   = evt_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                evt_next = in_evt;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        evt_reg <= evt_next;
    end

    assign out_valid = valid_reg;
    assign out_evt   = evt_reg;

endmodule

// ===== src/dfsec_engine.sv =====
`timescale 1ns / 1ps

module dfsec_engine
    import dfsec_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] n_vert,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  op_t                               in_op,
    input  logic [VTX_W-1:0]                  in_src,
    input  logic [VTX_W-1:0]                  in_dst,
    output logic                              ev_valid,
    input  logic                              ev_ready,
    output evt_t                              ev_data
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int STW   = AW + NW;
    localparam int CMP_W = ((NW > VTX_W) ? NW : VTX_W) + 1;

    eng_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic                    valid_rd_reg, valid_rd_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [NW-1:0]           sp_reg, sp_next;
    logic [NW-1:0]           scan_reg, scan_next;
    logic [AW-1:0]           top_vertex_reg, top_vertex_next;
    logic [NW-1:0]           top_nb_reg, top_nb_next;
    logic [AW-1:0]           root_reg, root_next;
    logic                    rhe_reg, rhe_next;
    logic                    had_reg, had_next;
    logic [AW-1:0]           ld_row_reg, ld_row_next;
    logic [AW-1:0]           ld_col_reg, ld_col_next;
    logic                    ld_ok_reg, ld_ok_next;
    evt_t                    evt_reg, evt_next;

    logic                    adj_we;
    logic [AW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [AW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    stk_we;
    logic [AW-1:0]           stk_waddr;
    logic [STW-1:0]          stk_wdata;
    logic [AW-1:0]           stk_raddr;
    logic [STW-1:0]          stk_rdata;

    logic [AW-1:0] scan_idx;
    logic [NW-1:0] top_idx;
    logic          scan_end;
    logic          row_hit;
    logic          vis_hit;
    logic          can_push;

    assign scan_idx = scan_reg[AW-1:0];
    assign top_idx  = sp_reg - NW'(1);
    assign scan_end = scan_reg >= n_vert;
    assign row_hit  = row_reg[scan_idx];
    assign vis_hit  = visited_reg[scan_idx];
    assign can_push = sp_reg < NW'(MAX_VERTICES);

    dfsec_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dfsec_ram #(
        .WIDTH (STW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_LOAD: state_next = ST_LOAD_WR;
                        OP_NEXT: state_next = ST_STEP;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_WR: state_next = ST_IDLE;
            ST_STEP: begin
                if (phase_reg != PH_WALK) begin
                    state_next = ST_EMIT;
                end else if (sp_reg == '0) begin
                    state_next = ST_RESTART;
                end else begin
                    state_next = ST_ROW_WAIT;
                end
            end
            ST_ROW_WAIT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = (sp_reg > NW'(1)) ? ST_POP_WAIT : ST_STEP;
                end else if (row_hit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_POP_WAIT: state_next = ST_STEP;
            ST_RESTART: begin
                if (scan_end || !vis_hit) begin
                    state_next = had_reg ? ST_EMIT : ST_STEP;
                end
            end
            ST_EMIT: begin
                if (ev_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready      = (state_reg == ST_IDLE);
        ev_valid      = (state_reg == ST_EMIT);
        ev_data       = evt_reg;
        adj_raddr     = (state_reg == ST_IDLE) ? AW'(in_src) : top_vertex_reg;
        valid_rd_next = row_valid_reg[adj_raddr];
        adj_we        = (state_reg == ST_LOAD_WR) && ld_ok_reg;
        adj_waddr     = ld_row_reg;
        adj_wdata     = (valid_rd_reg ? adj_rdata : '0)
                        | (MAX_VERTICES'(1) << ld_col_reg);
        stk_we        = (state_reg == ST_SCAN) && !scan_end && row_hit && !vis_hit
                        && can_push;
        stk_waddr     = AW'(top_idx);
        stk_wdata     = {top_vertex_reg, scan_reg + NW'(1)};
        stk_raddr     = AW'(sp_reg - NW'(2));
    end

    always_comb begin
        phase_next      = phase_reg;
        row_valid_next  = row_valid_reg;
        visited_next    = visited_reg;
        row_next        = row_reg;
        sp_next         = sp_reg;
        scan_next       = scan_reg;
        top_vertex_next = top_vertex_reg;
        top_nb_next     = top_nb_reg;
        root_next       = root_reg;
        rhe_next        = rhe_reg;
        had_next        = had_reg;
        ld_row_next     = ld_row_reg;
        ld_col_next     = ld_col_reg;
        ld_ok_next      = ld_ok_reg;
        evt_next        = evt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_CLEAR: begin
                            for (int r = 0; r < MAX_VERTICES; r++) begin
                                if (NW'(r) < n_vert) begin
                                    row_valid_next[r] = 1'b0;
                                end
                            end
                            visited_next = '0;
                            sp_next      = '0;
                            rhe_next     = 1'b0;
                            phase_next   = PH_IDLE;
                        end
                        OP_LOAD: begin
                            ld_row_next = AW'(in_src);
                            ld_col_next = AW'(in_dst);
                            ld_ok_next  = (CMP_W'(in_src) < CMP_W'(MAX_VERTICES))
                                          && (CMP_W'(in_dst) < CMP_W'(MAX_VERTICES));
                        end
                        OP_START: begin
                            visited_next    = MAX_VERTICES'(1);
                            top_vertex_next = '0;
                            top_nb_next     = '0;
                            sp_next         = NW'(1);
                            rhe_next        = 1'b0;
                            root_next       = '0;
                            phase_next      = PH_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD_WR: begin
                if (ld_ok_reg) begin
                    row_valid_next[ld_row_reg] = 1'b1;
                end
            end
            ST_STEP: begin
                if (phase_reg != PH_WALK) begin
                    evt_next.kind   = EV_DONE;
                    evt_next.from_v = '0;
                    evt_next.to_v   = '0;
                    evt_next.depth  = '0;
                end else if (sp_reg == '0) begin
                    had_next  = rhe_reg;
                    scan_next = '0;
                end
            end
            ST_ROW_WAIT: begin
                row_next  = valid_rd_reg ? adj_rdata : '0;
                scan_next = top_nb_reg;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    sp_next = top_idx;
                end else if (row_hit) begin
                    top_nb_next     = scan_reg + NW'(1);
                    evt_next.from_v = VTX_W'(top_vertex_reg);
                    evt_next.to_v   = VTX_W'(scan_reg);
                    evt_next.depth  = VTX_W'(top_idx);
                    if (sp_reg == NW'(1)) begin
                        rhe_next = 1'b1;
                    end
                    if (vis_hit) begin
                        evt_next.kind = EV_VISITED;
                    end else begin
                        evt_next.kind          = EV_TREE;
                        visited_next[scan_idx] = 1'b1;
                        if (can_push) begin
                            top_vertex_next = scan_idx;
                            top_nb_next     = '0;
                            sp_next         = sp_reg + NW'(1);
                        end
                    end
                end else begin
                    scan_next = scan_reg + NW'(1);
                end
            end
            ST_POP_WAIT: begin
                top_vertex_next = stk_rdata[STW-1:NW];
                top_nb_next     = stk_rdata[NW-1:0];
            end
            ST_RESTART: begin
                evt_next.kind   = EV_COMP_END;
                evt_next.from_v = VTX_W'(root_reg);
                evt_next.to_v   = '0;
                evt_next.depth  = '0;
                if (scan_end) begin
                    sp_next    = '0;
                    phase_next = PH_DONE;
                end else if (!vis_hit) begin
                    visited_next[scan_idx] = 1'b1;
                    top_vertex_next        = scan_idx;
                    top_nb_next            = '0;
                    sp_next                = NW'(1);
                    rhe_next               = 1'b0;
                    root_next              = scan_idx;
                    phase_next             = PH_WALK;
                end else begin
                    scan_next = scan_reg + NW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            row_valid_reg <= '0;
            visited_reg   <= '0;
            sp_reg        <= '0;
            rhe_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_valid_reg <= row_valid_next;
            visited_reg   <= visited_next;
            sp_reg        <= sp_next;
            rhe_reg       <= rhe_next;
        end
    end

    always_ff @(posedge clk) begin
        valid_rd_reg   <= valid_rd_next;
        row_reg        <= row_next;
        scan_reg       <= scan_next;
        top_vertex_reg <= top_vertex_next;
        top_nb_reg     <= top_nb_next;
        root_reg       <= root_next;
        had_reg        <= had_next;
        ld_row_reg     <= ld_row_next;
        ld_col_reg     <= ld_col_next;
        ld_ok_reg      <= ld_ok_next;
        evt_reg        <= evt_next;
    end

endmodule

// ===== src/dfs_edge_classifier_unit.sv =====
// Words are handled one at a time: clear and start act in the idle state, a load edge adds a write state.
// A next request passes through a step decision, a row read, a scan of the adjacency bits
// (the end of the row included), a stack read after a pop and a search of vertices for a new root
// as needed, then hands its word to the output register, where it waits while that register
// is full and m_tready is low; an idle or done request goes from the step decision to emit.
// Reset (aresetn low, synchronous) empties the matrix via row valid bits and idles the walk.
`timescale 1ns / 1ps

module dfs_edge_classifier_unit
    import dfsec_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // src_vertex[4:0], dst_vertex[9:5], zero fill
    input  logic [1:0]       s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // from_vertex[4:0], to_vertex[9:5], walk_depth[14:10]
    output logic [1:0]       m_tuser    // event_kind[1:0]
);

    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = ((NW > CNT_W) ? NW : CNT_W) + 1;

    logic [CNT_W-1:0] vertex_count_reg;
    logic [NW-1:0]    n_vert;
    logic             ev_valid;
    logic             ev_ready;
    evt_t             ev_data;
    evt_t             out_evt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= CNT_W'(1);
        end else if (cfg_we) begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (vertex_count_reg == '0) begin
            n_vert = NW'(1);
        end else if (CMP_W'(vertex_count_reg) > CMP_W'(MAX_VERTICES)) begin
            n_vert = NW'(MAX_VERTICES);
        end else begin
            n_vert = NW'(vertex_count_reg);
        end
    end

    dfsec_engine #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_engine (
        .clk      (aclk),
        .rst_n    (aresetn),
        .n_vert   (n_vert),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (op_t'(s_tuser)),
        .in_src   (s_tdata[4:0]),
        .in_dst   (s_tdata[9:5]),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .ev_data  (ev_data)
    );

    dfsec_out_reg u_out_reg (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (ev_valid),
        .in_ready  (ev_ready),
        .in_evt    (ev_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_evt   (out_evt)
    );

    assign m_tdata = {1'b0, out_evt.depth, out_evt.to_v, out_evt.from_v};
    assign m_tuser = out_evt.kind;

endmodule

// ===== src/dfsec_checker.sv =====
`timescale 1ns / 1ps
`include "dfs_edge_classifier_unit_assert.svh"

module dfsec_checker
    import dfsec_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `DFSEC_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "word valid after reset")
    `DFSEC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")
    `DFSEC_ASSERT(a_done_zero, aclk, aresetn, m_tvalid && (m_tuser == EV_DONE) |-> (m_tdata == '0), "done word carries data")
    `DFSEC_ASSERT(a_comp_end_zero, aclk, aresetn, m_tvalid && (m_tuser == EV_COMP_END) |-> (m_tdata[15:5] == '0), "component end carries edge data")
    `DFSEC_ASSERT(a_accept_no_emit, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid), "word emitted right after accept")

endmodule

bind dfs_edge_classifier_unit dfsec_checker u_dfsec_checker (.*);
